// ----- rtl/core/hsl2rgb_pkg.sv -----
// constants and types shared by the hsl to rgb conversion pipeline
package hsl2rgb_pkg;

  // field widths
  localparam int HUE_W = 9;
  localparam int PCT_W = 7;
  localparam int CH_W  = 8;

  // internal widths
  localparam int SPAN_W = 8;   // 100 - |2l - 100|, signed, -54..100
  localparam int SS_W   = 16;  // span * s, signed
  localparam int LM_W   = 20;  // l * 6000, unsigned
  localparam int T_W    = 6;   // hue fraction in degrees, 0..60
  localparam int UNIT_W = 24;  // values over the 600000 denominator, signed
  localparam int MAG_W  = 22;  // magnitude of a positive unit value
  localparam int P_W    = 27;  // unit value times 17
  localparam int N_W    = 18;  // (unit * 17) / 64 below the clamp level
  localparam int PRD_W  = 37;  // reciprocal product

  // hue geometry
  localparam logic [HUE_W-1:0] HUE_LIMIT  = 9'd360;
  localparam logic [HUE_W-1:0] SECTOR_DEG = 9'd60;
  localparam logic [HUE_W-1:0] PAIR_DEG   = 9'd120;

  // lightness midpoint and span terms
  localparam logic [PCT_W-1:0] L_HALF   = 7'd50;
  localparam logic [8:0]       SPAN_TOP = 9'd200;

  // scale factors in units of 1/600000
  localparam logic [LM_W-1:0]          L_UNIT   = 20'd6000;
  localparam logic signed [UNIT_W-1:0] C_FACTOR = 24'sd60;
  localparam logic signed [UNIT_W-1:0] M_FACTOR = 24'sd30;

  // 255/600000 = 17/40000; 40000 = 64 * 625
  localparam logic [P_W-1:0]   SCALE_NUM  = 27'd17;
  localparam logic [P_W-1:0]   CLAMP_LVL  = 27'd10240000;  // 256 * 40000
  localparam int               DIV_SHIFT  = 6;
  localparam logic [PRD_W-1:0] RECIP_625  = 37'd429497;    // ceil(2^28 / 625)
  localparam int               RECIP_SH   = 28;
  localparam logic [CH_W-1:0]  FULL_SCALE = 8'd255;

  // 60-degree sector of the hue wheel
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  // per-channel clamp flags after scaling
  typedef struct packed {
    logic pos;   // unit value above zero
    logic over;  // scaled value past full scale, at 256 or more
  } ch_flags_t;

endpackage

// ----- rtl/core/hsl_to_rgb_converter.sv -----
// hsl to rgb color converter, six-stage pipeline
//
//  channel | ports                                          | direction | beat
//  --------+------------------------------------------------+-----------+-----------------------
//  input   | start, busy, in_hue_deg, in_saturation_pct,    | in        | start && !busy
//          | in_lightness_pct                               |           |
//  result  | out_valid, out_red, out_green, out_blue,       | out       | out_valid, one cycle
//          | out_hue_error                                  |           |
//
// one color is taken every cycle; busy is never raised
// each result leaves once its input beat has passed through the six register stages
// (decode, span product, chroma products, channel sums, scale, reciprocal divide)
// reset clears the stage valid bits only; payload registers carry no reset
// the receiver cannot stall, so results are never held back
module hsl_to_rgb_converter (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [hsl2rgb_pkg::HUE_W-1:0]   in_hue_deg,
  input  logic [hsl2rgb_pkg::PCT_W-1:0]   in_saturation_pct,
  input  logic [hsl2rgb_pkg::PCT_W-1:0]   in_lightness_pct,
  output logic                            out_valid,
  output logic [hsl2rgb_pkg::CH_W-1:0]    out_red,
  output logic [hsl2rgb_pkg::CH_W-1:0]    out_green,
  output logic [hsl2rgb_pkg::CH_W-1:0]    out_blue,
  output logic                            out_hue_error
);
  import hsl2rgb_pkg::*;

  // stage valid bits
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic in_beat;

  // stage 1: hue decode and lightness span
  logic signed [SPAN_W-1:0] span_r, span_nxt;
  logic [PCT_W-1:0]         sat_r, lit_r;
  logic [T_W-1:0]           t1_r, t_nxt;
  sector_t                  sec1_r, sec_nxt;
  logic                     err1_r, err_nxt;
  logic [HUE_W-1:0]         hue_off;
  logic [HUE_W-1:0]         hue_mod;
  logic [8:0]               span_wide;

  // stage 2: span times saturation
  logic signed [SS_W-1:0] ss_r, ss_nxt;
  logic [LM_W-1:0]        lm_r, lm_nxt;
  logic [T_W-1:0]         t2_r;
  sector_t                sec2_r;
  logic                   err2_r;

  // stage 3: chroma, hue term and offset
  logic signed [UNIT_W-1:0] c_r, x_r, m_r, c_nxt, x_nxt, m_nxt;
  logic signed [UNIT_W-1:0] ss_ext, t_ext, half_c;
  sector_t                  sec3_r;
  logic                     err3_r;

  // stage 4: channel unit values
  logic signed [UNIT_W-1:0] u_r [3];
  logic signed [UNIT_W-1:0] u_nxt [3];
  logic                     err4_r;

  // stage 5: scale by 17/64 and clamp flags
  logic [N_W-1:0] n_r [3];
  logic [N_W-1:0] n_nxt [3];
  ch_flags_t      fl_r [3];
  ch_flags_t      fl_nxt [3];
  logic [P_W-1:0] p_w [3];
  logic           err5_r;

  // stage 6: divide by 625 through a reciprocal
  logic [PRD_W-1:0] prd_w [3];
  logic [CH_W-1:0]  ch_nxt [3];
  logic [CH_W-1:0]  red_r, green_r, blue_r;
  logic             err6_r;

  assign busy    = 1'b0;
  assign in_beat = start && !busy;

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      v1_r <= in_beat;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  // sector, fraction within the 120-degree pair, lightness span
  always_comb begin
    err_nxt = (in_hue_deg >= HUE_LIMIT);
    if (in_hue_deg < SECTOR_DEG) begin
      sec_nxt = SEC_RED_YEL;
      hue_off = '0;
    end else if (in_hue_deg < HUE_W'(2 * SECTOR_DEG)) begin
      sec_nxt = SEC_YEL_GRN;
      hue_off = '0;
    end else if (in_hue_deg < HUE_W'(3 * SECTOR_DEG)) begin
      sec_nxt = SEC_GRN_CYN;
      hue_off = PAIR_DEG;
    end else if (in_hue_deg < HUE_W'(4 * SECTOR_DEG)) begin
      sec_nxt = SEC_CYN_BLU;
      hue_off = PAIR_DEG;
    end else if (in_hue_deg < HUE_W'(5 * SECTOR_DEG)) begin
      sec_nxt = SEC_BLU_MAG;
      hue_off = HUE_W'(2 * PAIR_DEG);
    end else begin
      sec_nxt = SEC_MAG_RED;
      hue_off = HUE_W'(2 * PAIR_DEG);
    end
    hue_mod = in_hue_deg - hue_off;
    // t = 60 - |hue mod 120 - 60|
    if (hue_mod >= SECTOR_DEG) begin
      t_nxt = T_W'(PAIR_DEG - hue_mod);
    end else begin
      t_nxt = T_W'(hue_mod);
    end
    // span = 100 - |2l - 100|
    if (in_lightness_pct >= L_HALF) begin
      span_wide = SPAN_TOP - {1'b0, in_lightness_pct, 1'b0};
    end else begin
      span_wide = {1'b0, in_lightness_pct, 1'b0};
    end
    span_nxt = $signed(span_wide[SPAN_W-1:0]);
  end

  // span product and lightness offset
  always_comb begin
    ss_nxt = SS_W'(span_r) * SS_W'($signed({1'b0, sat_r}));
    lm_nxt = LM_W'(lit_r) * L_UNIT;
  end

  // chroma c, hue term x and offset m
  always_comb begin
    ss_ext = UNIT_W'(ss_r);
    t_ext  = $signed(UNIT_W'(t2_r));
    half_c = ss_ext * M_FACTOR;
    c_nxt  = ss_ext * C_FACTOR;
    x_nxt  = ss_ext * t_ext;
    m_nxt  = $signed(UNIT_W'(lm_r)) - half_c;
  end

  // channel order from the sector
  always_comb begin
    unique case (sec3_r)
      SEC_RED_YEL: begin
        u_nxt[0] = c_r + m_r; u_nxt[1] = x_r + m_r; u_nxt[2] = m_r;
      end
      SEC_YEL_GRN: begin
        u_nxt[0] = x_r + m_r; u_nxt[1] = c_r + m_r; u_nxt[2] = m_r;
      end
      SEC_GRN_CYN: begin
        u_nxt[0] = m_r;       u_nxt[1] = c_r + m_r; u_nxt[2] = x_r + m_r;
      end
      SEC_CYN_BLU: begin
        u_nxt[0] = m_r;       u_nxt[1] = x_r + m_r; u_nxt[2] = c_r + m_r;
      end
      SEC_BLU_MAG: begin
        u_nxt[0] = x_r + m_r; u_nxt[1] = m_r;       u_nxt[2] = c_r + m_r;
      end
      SEC_MAG_RED: begin
        u_nxt[0] = c_r + m_r; u_nxt[1] = m_r;       u_nxt[2] = x_r + m_r;
      end
      default: begin
        u_nxt[0] = m_r;       u_nxt[1] = m_r;       u_nxt[2] = m_r;
      end
    endcase
  end

  // times 17, clamp test, drop six low bits
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p_w[i]        = P_W'(u_r[i][MAG_W-1:0]) * SCALE_NUM;
      fl_nxt[i].pos  = !u_r[i][UNIT_W-1] && (u_r[i] != '0);
      fl_nxt[i].over = (p_w[i] >= CLAMP_LVL);
      n_nxt[i]       = p_w[i][DIV_SHIFT +: N_W];
    end
  end

  // divide by 625 and pick zero, full scale or quotient
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prd_w[i] = PRD_W'(n_r[i]) * RECIP_625;
      if (err5_r || !fl_r[i].pos) begin
        ch_nxt[i] = '0;
      end else if (fl_r[i].over) begin
        ch_nxt[i] = FULL_SCALE;
      end else begin
        ch_nxt[i] = prd_w[i][RECIP_SH +: CH_W];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    span_r  <= span_nxt;
    sat_r   <= in_saturation_pct;
    lit_r   <= in_lightness_pct;
    t1_r    <= t_nxt;
    sec1_r  <= sec_nxt;
    err1_r  <= err_nxt;

    ss_r    <= ss_nxt;
    lm_r    <= lm_nxt;
    t2_r    <= t1_r;
    sec2_r  <= sec1_r;
    err2_r  <= err1_r;

    c_r     <= c_nxt;
    x_r     <= x_nxt;
    m_r     <= m_nxt;
    sec3_r  <= sec2_r;
    err3_r  <= err2_r;

    for (int i = 0; i < 3; i++) begin
      u_r[i]  <= u_nxt[i];
      n_r[i]  <= n_nxt[i];
      fl_r[i] <= fl_nxt[i];
    end
    err4_r  <= err3_r;
    err5_r  <= err4_r;

    red_r   <= ch_nxt[0];
    green_r <= ch_nxt[1];
    blue_r  <= ch_nxt[2];
    err6_r  <= err5_r;
  end

  assign out_valid     = v6_r;
  assign out_red       = red_r;
  assign out_green     = green_r;
  assign out_blue      = blue_r;
  assign out_hue_error = err6_r;

  // every result comes from a matching earlier input beat
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_beat, 6))
    else $error("result without matching input beat");

  // error flag follows the hue of that beat
  a_err_hue: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hue_error == ($past(in_hue_deg, 6) >= HUE_LIMIT)))
    else $error("hue error flag does not match input hue");

  // out-of-range hue gives black
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hue_error |-> (out_red == '0) && (out_green == '0) && (out_blue == '0))
    else $error("channels not zero on hue error");

  // zero saturation gives a grey
  a_grey: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hue_error && ($past(in_saturation_pct, 6) == '0)
      |-> (out_red == out_green) && (out_green == out_blue))
    else $error("zero saturation did not give equal channels");

endmodule
